FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file dtt_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables
`define DTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset disables
`define DTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/dtt_pkg.sv
// types, codes and defaults of the deadline timer table
// no dependencies
`timescale 1ns / 1ps

package dtt_pkg;

  localparam int unsigned DefaultSlots  = 16;
  localparam logic [31:0] DefaultWindow = 32'd3600000;
  localparam int unsigned MaxOut        = 16;

  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_CANCEL   = 3'd1;
  localparam logic [2:0] CMD_REFRESH  = 3'd2;
  localparam logic [2:0] CMD_RESET    = 3'd3;
  localparam logic [2:0] CMD_NEXTWAIT = 3'd4;
  localparam logic [2:0] CMD_EXPIRE   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] now_ms;
    logic [3:0]  timer_slot;
    logic [31:0] period_ms;
    logic        repeat_req;
    logic        restart_now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic [63:0] wait_ms;
    logic        front_notify;
    logic        last;
    logic        any_active;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       add_wr;
    logic       cancel;
    logic       refresh_wr;
    logic       reset_wr;
    logic       scan_go;
    logic       scan_filt;
    logic       exp_chk;
    logic       push;
    logic       upd_rd;
    logic       upd_wr;
    logic       front_chk;
    logic       wait_clr;
    logic       emit;
    logic [1:0] emit_status;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       slot_valid;
    logic       slot_ok;
    logic       slot_act;
    logic       full;
    logic       scan_busy;
    logic       found;
    logic       due;
    logic       period_same;
    logic       fnow;
    logic       list_full;
    logic       k_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/dtt_dp.sv
// datapath: slot flags, period and deadline memories, scan engine, result register
// depends on dtt_pkg
`timescale 1ns / 1ps

module dtt_dp #(
  parameter int unsigned TimerSlots = dtt_pkg::DefaultSlots
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dtt_pkg::req_t    req_i,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  dtt_pkg::dp_ctl_t ctl_i,
  output dtt_pkg::dp_stat_t stat_o,
  output logic             result_valid_o,
  output dtt_pkg::res_t    result_o
);
  import dtt_pkg::*;

  localparam int unsigned IdxW = $clog2(TimerSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TimerSlots - 1);
  localparam logic [4:0] ListMax = 5'(MaxOut);

  req_t            req_q;
  logic [31:0]     window_q;
  logic [63:0]     prev_q;
  logic            pending_q;
  logic            roll_q;
  logic [TimerSlots-1:0] active_q, active_d;
  logic [TimerSlots-1:0] rec_q, rec_d;
  logic [TimerSlots-1:0] taken_q;

  logic [31:0]     per_mem [TimerSlots];
  logic [63:0]     dl_mem  [TimerSlots];
  logic [31:0]     rd_per_q;
  logic [63:0]     rd_dl_q;

  logic            scn_act_q;
  logic [IdxW-1:0] ptr_q;
  logic            cmp_v_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            filt_q;
  logic            best_v_q;
  logic [IdxW-1:0] best_idx_q;
  logic [63:0]     best_dl_q;

  logic [IdxW-1:0] list_q [MaxOut];
  logic [4:0]      cnt_q;
  logic [3:0]      k_q;
  logic [IdxW-1:0] tgt_q;

  logic            out_v_q;
  res_t            out_q;

  logic [IdxW-1:0] slot_idx, free_idx, raddr, waddr, upd_idx;
  logic            slot_valid, free_found, cand, better, roll_c, k_last;
  logic            wr_en, wr_per_en, front_c, last_c;
  logic [31:0]     wper;
  logic [63:0]     now, wdl, dl_add, dl_now_per, reset_start, dl_reset, wait_c;
  logic [3:0]      rs_slot;

  assign now        = req_q.now_ms;
  assign slot_idx   = IdxW'(req_q.timer_slot);
  assign slot_valid = 32'(req_q.timer_slot) < TimerSlots;
  assign upd_idx    = list_q[k_q];
  assign k_last     = {1'b0, k_q} == (cnt_q - 5'd1);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TimerSlots - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign dl_add      = now + 64'(req_q.period_ms);
  assign dl_now_per  = now + 64'(rd_per_q);
  assign reset_start = req_q.restart_now ? now : (rd_dl_q - 64'(rd_per_q));
  assign dl_reset    = reset_start + 64'(req_q.period_ms);
  assign roll_c      = (now < prev_q) && ((prev_q - now) > 64'(window_q));

  // write port select
  always_comb begin
    wr_en     = 1'b0;
    wr_per_en = 1'b0;
    waddr     = slot_idx;
    wper      = req_q.period_ms;
    wdl       = dl_now_per;
    if (ctl_i.add_wr) begin
      wr_en     = 1'b1;
      wr_per_en = 1'b1;
      waddr     = free_idx;
      wdl       = dl_add;
    end else if (ctl_i.refresh_wr) begin
      wr_en = 1'b1;
    end else if (ctl_i.reset_wr) begin
      wr_en     = 1'b1;
      wr_per_en = 1'b1;
      wdl       = dl_reset;
    end else if (ctl_i.upd_wr) begin
      wr_en = rec_q[upd_idx];
      waddr = upd_idx;
    end
  end

  always_comb begin
    if (scn_act_q) begin
      raddr = ptr_q;
    end else if (ctl_i.upd_rd) begin
      raddr = upd_idx;
    end else begin
      raddr = slot_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dl_mem[waddr] <= wdl;
      if (wr_per_en) begin
        per_mem[waddr] <= wper;
      end
    end
    rd_dl_q  <= dl_mem[raddr];
    rd_per_q <= per_mem[raddr];
  end

  // flag updates
  always_comb begin
    active_d = active_q;
    rec_d    = rec_q;
    if (ctl_i.add_wr) begin
      active_d[free_idx] = 1'b1;
      rec_d[free_idx]    = req_q.repeat_req;
    end
    if (ctl_i.cancel && slot_valid) begin
      active_d[slot_idx] = 1'b0;
    end
    if (ctl_i.upd_wr && !rec_q[upd_idx]) begin
      active_d[upd_idx] = 1'b0;
    end
  end

  assign cand = cmp_v_q && active_q[cmp_idx_q] && !taken_q[cmp_idx_q]
                && (!filt_q || roll_q || (rd_dl_q <= now));
  assign better = cand && (!best_v_q || (rd_dl_q < best_dl_q));

  assign front_c = ctl_i.front_chk && best_v_q && (best_idx_q == tgt_q) && !pending_q;

  always_comb begin
    if (!best_v_q) begin
      wait_c = '1;
    end else if (now >= best_dl_q) begin
      wait_c = '0;
    end else begin
      wait_c = best_dl_q - now;
    end
  end

  always_comb begin
    if ((ctl_i.emit_status == ST_FULL) || (ctl_i.emit_status == ST_NONE)
        || (req_q.command == CMD_NEXTWAIT)) begin
      rs_slot = '0;
    end else if (req_q.command == CMD_ADD) begin
      rs_slot = 4'(tgt_q);
    end else if (req_q.command == CMD_EXPIRE) begin
      rs_slot = 4'(upd_idx);
    end else begin
      rs_slot = req_q.timer_slot;
    end
  end

  assign last_c = !((req_q.command == CMD_EXPIRE) && (ctl_i.emit_status == ST_OK)) || k_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= DefaultWindow;
      prev_q    <= '0;
      pending_q <= 1'b0;
      roll_q    <= 1'b0;
      active_q  <= '0;
      rec_q     <= '0;
      taken_q   <= '0;
      scn_act_q <= 1'b0;
      ptr_q     <= '0;
      cmp_v_q   <= 1'b0;
      best_v_q  <= 1'b0;
      cnt_q     <= '0;
      k_q       <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      active_q <= active_d;
      rec_q    <= rec_d;
      cmp_v_q  <= scn_act_q;
      out_v_q  <= ctl_i.emit;
      if (ctl_i.load) begin
        taken_q <= '0;
        cnt_q   <= '0;
        k_q     <= '0;
      end
      if (ctl_i.scan_go) begin
        scn_act_q <= 1'b1;
        ptr_q     <= '0;
        best_v_q  <= 1'b0;
      end else begin
        if (scn_act_q) begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LastIdx) begin
            scn_act_q <= 1'b0;
          end
        end
        if (better) begin
          best_v_q <= 1'b1;
        end
      end
      if (ctl_i.exp_chk) begin
        prev_q <= now;
        roll_q <= roll_c;
      end
      if (ctl_i.push) begin
        taken_q[best_idx_q] <= 1'b1;
        cnt_q               <= cnt_q + 5'd1;
      end
      if (ctl_i.upd_wr) begin
        k_q <= k_last ? '0 : k_q + 4'd1;
      end else if (ctl_i.emit && (req_q.command == CMD_EXPIRE)
                   && (ctl_i.emit_status == ST_OK)) begin
        k_q <= k_q + 4'd1;
      end
      if (front_c) begin
        pending_q <= 1'b1;
      end else if (ctl_i.wait_clr) begin
        pending_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    cmp_idx_q <= ptr_q;
    if (ctl_i.scan_go) begin
      filt_q <= ctl_i.scan_filt;
    end
    if (better && !ctl_i.scan_go) begin
      best_idx_q <= cmp_idx_q;
      best_dl_q  <= rd_dl_q;
    end
    if (ctl_i.push) begin
      list_q[cnt_q[3:0]] <= best_idx_q;
    end
    if (ctl_i.add_wr) begin
      tgt_q <= free_idx;
    end else if (ctl_i.reset_wr) begin
      tgt_q <= slot_idx;
    end
    if (ctl_i.emit) begin
      out_q.status       <= ctl_i.emit_status;
      out_q.result_slot  <= rs_slot;
      out_q.wait_ms      <= (req_q.command == CMD_NEXTWAIT) ? wait_c : '0;
      out_q.front_notify <= front_c;
      out_q.last         <= last_c;
      out_q.any_active   <= |active_d;
    end
  end

  assign stat_o.cmd         = req_q.command;
  assign stat_o.slot_valid  = slot_valid;
  assign stat_o.slot_ok     = slot_valid && active_q[slot_idx];
  assign stat_o.slot_act    = active_q[slot_idx];
  assign stat_o.full        = !free_found;
  assign stat_o.scan_busy   = scn_act_q || cmp_v_q;
  assign stat_o.found       = best_v_q;
  assign stat_o.due         = roll_c || (best_dl_q <= now);
  assign stat_o.period_same = req_q.period_ms == rd_per_q;
  assign stat_o.fnow        = req_q.restart_now;
  assign stat_o.list_full   = cnt_q == ListMax;
  assign stat_o.k_last      = k_last;

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

endmodule

FILE: hw/rtl/dtt_ctrl.sv
// controller: sequences each request through the datapath
// depends on dtt_pkg
`timescale 1ns / 1ps

module dtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dtt_pkg::dp_stat_t stat_i,
  output dtt_pkg::dp_ctl_t  ctl_o
);
  import dtt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_RDW    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_UPD_RD = 3'd5;
  localparam logic [2:0] S_UPD_WR = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  assign busy = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        case (stat_i.cmd) inside
          CMD_ADD: begin
            if (stat_i.full) begin
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = ST_FULL;
            end else begin
              ctl_o.add_wr  = 1'b1;
              ctl_o.scan_go = 1'b1;
              state_d       = S_SCAN;
            end
          end
          CMD_CANCEL: begin
            ctl_o.cancel      = stat_i.slot_ok;
            ctl_o.emit        = 1'b1;
            ctl_o.emit_status = stat_i.slot_ok ? ST_OK : ST_INACTIVE;
          end
          CMD_REFRESH: begin
            if (stat_i.slot_ok) begin
              state_d = S_RDW;
            end else begin
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = ST_INACTIVE;
            end
          end
          CMD_RESET: begin
            if (stat_i.slot_valid) begin
              state_d = S_RDW;
            end else begin
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = ST_INACTIVE;
            end
          end
          CMD_NEXTWAIT, CMD_EXPIRE: begin
            ctl_o.scan_go = 1'b1;
            state_d       = S_SCAN;
          end
          default: ;
        endcase
      end
      S_RDW: begin
        state_d = S_IDLE;
        if (stat_i.cmd == CMD_REFRESH) begin
          ctl_o.refresh_wr  = 1'b1;
          ctl_o.emit        = 1'b1;
          ctl_o.emit_status = ST_OK;
        end else if (stat_i.period_same && !stat_i.fnow) begin
          ctl_o.emit        = 1'b1;
          ctl_o.emit_status = ST_OK;
        end else if (!stat_i.slot_act) begin
          ctl_o.emit        = 1'b1;
          ctl_o.emit_status = ST_INACTIVE;
        end else begin
          ctl_o.reset_wr = 1'b1;
          ctl_o.scan_go  = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat_i.scan_busy) begin
          state_d = S_IDLE;
          if (stat_i.cmd == CMD_EXPIRE) begin
            if (!stat_i.found) begin
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = ST_NONE;
            end else if (!stat_i.due) begin
              ctl_o.exp_chk     = 1'b1;
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = ST_NONE;
            end else begin
              ctl_o.exp_chk   = 1'b1;
              ctl_o.scan_go   = 1'b1;
              ctl_o.scan_filt = 1'b1;
              state_d         = S_PICK;
            end
          end else if (stat_i.cmd == CMD_NEXTWAIT) begin
            ctl_o.wait_clr    = 1'b1;
            ctl_o.emit        = 1'b1;
            ctl_o.emit_status = ST_OK;
          end else begin
            ctl_o.front_chk   = 1'b1;
            ctl_o.emit        = 1'b1;
            ctl_o.emit_status = ST_OK;
          end
        end
      end
      S_PICK: begin
        if (!stat_i.scan_busy) begin
          if (stat_i.found && !stat_i.list_full) begin
            ctl_o.push      = 1'b1;
            ctl_o.scan_go   = 1'b1;
            ctl_o.scan_filt = 1'b1;
          end else begin
            state_d = S_UPD_RD;
          end
        end
      end
      S_UPD_RD: begin
        ctl_o.upd_rd = 1'b1;
        state_d      = S_UPD_WR;
      end
      S_UPD_WR: begin
        ctl_o.upd_wr = 1'b1;
        state_d      = stat_i.k_last ? S_EMIT : S_UPD_RD;
      end
      S_EMIT: begin
        ctl_o.emit        = 1'b1;
        ctl_o.emit_status = ST_OK;
        if (stat_i.k_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/deadline_timer_table.sv
// top level of the deadline timer table: controller plus datapath
// depends on dtt_pkg, dtt_ctrl, dtt_dp
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; each result appears
// for one cycle with result_valid_o and cannot be held off, the final one
// marked by last. Add, next-wait, expire and a reset that moves the timer scan
// the table; an expire of n due timers scans once more per due timer and once
// more to find none left. Every scan walks the deadline memory one slot per
// cycle through its single read port. The user must write the rollover window
// with cfg_we_i only while the block is idle; the block does not enforce this.
module deadline_timer_table #(
  parameter int unsigned TimerSlots = dtt_pkg::DefaultSlots
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dtt_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  output logic          result_valid_o,
  output dtt_pkg::res_t result_o
);
  import dtt_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  dtt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  dtt_dp #(
    .TimerSlots(TimerSlots)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: hw/rtl/dtt_checker.sv
// port-level checks on the deadline timer table, bound to the top level
// depends on dtt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input dtt_pkg::res_t result_o
);
  import dtt_pkg::*;

  `DTT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `DTT_ASSERT_SAME(a_result_in_request, clk_i, rst_ni, result_valid_o, $past(busy))
  `DTT_ASSERT_SAME(a_error_last, clk_i, rst_ni, result_valid_o && (result_o.status != ST_OK), result_o.last)
  `DTT_ASSERT_SAME(a_front_single, clk_i, rst_ni, result_valid_o && result_o.front_notify, result_o.last && (result_o.status == ST_OK) && result_o.any_active)

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (.*);
